/* rtl/core/mtfh_pkg.sv */
// Package for the mutex table with FIFO handoff.
// Holds command and status codes, the transaction structs and the sequencer states; no dependencies.
`default_nettype none
package mtfh_pkg;
    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_LOCK   = 3'd1,
        CMD_UNLOCK = 3'd2,
        CMD_DETECT = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_BUSY       = 3'd2,
        ST_NOT_LOCKED = 3'd3,
        ST_DENIED     = 3'd4,
        ST_FULL       = 3'd5,
        ST_DEADLOCK   = 3'd6
    } t_status;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] mutex_id;
        logic [5:0] proc_id;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] new_slot;
        logic       was_queued;
        logic       handed_off;
        logic [5:0] new_owner;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CREATE,
        S_RD_HEAD,
        S_SHIFT,
        S_CLEAR,
        S_BUILD,
        S_WALK_INIT,
        S_WALK,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

/* rtl/core/mtfh_qmem.sv */
// Waiter queue storage: one memory of NUM_MUTEXES*QUEUE_DEPTH process ids.
// One write and one registered read port; uses mtfh_pkg.
`default_nettype none
module mtfh_qmem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [5:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [5:0]         o_rdata
);
    import mtfh_pkg::*;
    logic [5:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/mutex_table_fifo_handoff.sv */
// Top level of the mutex table with FIFO handoff: sequencer and slot table.
// Uses mtfh_pkg and mtfh_qmem.
//
// Usage: one command transaction enters on i_in_valid/o_in_stall; one
// result transaction leaves on o_out_valid/i_out_stall for every command.
// The block handles one command at a time and stalls input until the result
// register is taken. Work from acceptance to result valid, by command:
//   create: one slot examined per cycle, lowest first, up to a free or the last slot
//   lock, unlock to free, errors, unknown: decode, then result
//   unlock with handoff: head read, then queue shifted one entry per cycle
//   clear: one slot cleared per cycle
//   detect: bounded by the single queue read port while building the wait-for
//   map and by walking the map one hop at a time (registered map read).
// Reset empties the table; the queue memory holds no reset and its data is only used
// below each mutex's waiter count. While the receiver stalls, the result
// holds and no new command is accepted.
`default_nettype none
module mutex_table_fifo_handoff #(
    parameter int NUM_MUTEXES = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int PROC_SLOTS  = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire mtfh_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output mtfh_pkg::t_out     o_out
);
    import mtfh_pkg::*;

    localparam int MW  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
    localparam int AW  = $clog2(NUM_MUTEXES * QUEUE_DEPTH) > 0 ?
                         $clog2(NUM_MUTEXES * QUEUE_DEPTH) : 1;
    localparam int KW  = $clog2(PROC_SLOTS + 1);
    localparam int UW  = $clog2(NUM_MUTEXES + 1);

    logic [NUM_MUTEXES-1:0] r_active, r_locked;
    logic [5:0]    r_owner [NUM_MUTEXES];
    logic [CW-1:0] r_cnt   [NUM_MUTEXES];
    logic [UW-1:0] r_in_use;
    logic [PROC_SLOTS-1:0] r_ev;
    logic [5:0]    r_eto   [PROC_SLOTS];
    logic [5:0]    r_eto_rd;

    t_state r_state, n_state;
    t_in    r_req;
    t_out   r_res;
    logic   r_ovalid;

    // scan / walk counters
    logic [MW-1:0] r_m;
    logic [CW-1:0] r_j;
    logic [PW-1:0] r_s;
    logic [5:0]    r_node;
    logic [KW-1:0] r_k;
    logic          r_ph;      // walk phase: map read in flight, then evaluate
    logic          r_rd_ok;   // a queue read issued last cycle is valid
    logic [5:0]    r_rd_own;

    logic          q_we;
    logic [AW-1:0] q_waddr, q_raddr;
    logic [5:0]    q_wdata, q_rdata;

    mtfh_qmem #(.DEPTH(NUM_MUTEXES * QUEUE_DEPTH), .AW(AW)) u_qmem (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    logic [MW-1:0] mid;
    logic          mid_ok;
    logic [AW-1:0] base;
    assign mid    = MW'(r_req.mutex_id);
    assign mid_ok = ({28'd0, r_req.mutex_id} < NUM_MUTEXES) && r_active[mid];
    assign base   = AW'(mid) * AW'(QUEUE_DEPTH);

    logic [AW-1:0] scan_addr;
    assign scan_addr = AW'(r_m) * AW'(QUEUE_DEPTH) + AW'(r_j);

    logic last_m;
    assign last_m = (32'(r_m) == NUM_MUTEXES - 1);

    logic walk_end;
    assign walk_end = (32'(r_node) >= PROC_SLOTS) || !r_ev[PW'(r_node)];

    assign o_in_stall  = (r_state != S_IDLE) || r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_res;

    always_comb begin
        n_state = r_state;
        q_we    = 1'b0;
        q_waddr = base + AW'(r_cnt[mid]);
        q_wdata = r_req.proc_id;
        q_raddr = scan_addr;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_req.cmd)
                    CMD_CREATE: n_state = S_CREATE;
                    CMD_LOCK: begin
                        n_state = S_DONE;
                        if (mid_ok && r_locked[mid] && r_owner[mid] != r_req.proc_id
                            && 32'(r_cnt[mid]) < QUEUE_DEPTH) begin
                            q_we = 1'b1;
                        end
                    end
                    CMD_UNLOCK: begin
                        n_state = S_DONE;
                        q_raddr = base;
                        if (mid_ok && r_locked[mid] && r_owner[mid] == r_req.proc_id
                            && r_cnt[mid] != '0) n_state = S_RD_HEAD;
                    end
                    CMD_DETECT: n_state = S_BUILD;
                    CMD_CLEAR:  n_state = S_CLEAR;
                    default:    n_state = S_DONE;
                endcase
            end
            S_CREATE: begin
                if (!r_active[r_m] || last_m) n_state = S_DONE;
            end
            S_RD_HEAD: begin
                q_raddr = base + AW'(r_j) + AW'(1);
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // move entry j+1 down to j, read j+2 ahead
                q_raddr = base + AW'(r_j) + AW'(2);
                if (32'(r_j) + 1 < 32'(r_cnt[mid])) begin
                    q_we    = 1'b1;
                    q_waddr = base + AW'(r_j);
                    q_wdata = q_rdata;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                if (last_m) n_state = S_DONE;
            end
            S_BUILD: begin
                if (last_m && !(r_active[r_m] && r_locked[r_m] && r_j < r_cnt[r_m]))
                    n_state = S_WALK_INIT;
            end
            S_WALK_INIT: n_state = S_WALK;
            S_WALK: begin
                if (r_res.status == ST_DEADLOCK) n_state = S_DONE;
                else if (r_ph && walk_end && 32'(r_s) == PROC_SLOTS - 1) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // registered read of the wait-for map at the current node
    always_ff @(posedge i_clk) begin
        r_eto_rd <= r_eto[PW'(r_node)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_active <= '0;
            r_locked <= '0;
            r_in_use <= '0;
            for (int i = 0; i < NUM_MUTEXES; i++) r_cnt[i] <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_req <= i_in;
                        r_res <= '0;
                        r_m   <= '0;
                        r_j   <= '0;
                    end
                end
                S_DECODE: begin
                    case (r_req.cmd)
                        CMD_CREATE: begin
                            if (32'(r_in_use) >= NUM_MUTEXES) r_res.status <= ST_FULL;
                        end
                        CMD_LOCK: begin
                            if (!mid_ok) begin
                                r_res.status <= ST_NOT_FOUND;
                            end else if (!r_locked[mid]) begin
                                r_locked[mid] <= 1'b1;
                                r_owner[mid]  <= r_req.proc_id;
                            end else begin
                                r_res.status <= ST_BUSY;
                                if (r_owner[mid] != r_req.proc_id
                                    && 32'(r_cnt[mid]) < QUEUE_DEPTH) begin
                                    r_cnt[mid]       <= r_cnt[mid] + CW'(1);
                                    r_res.was_queued <= 1'b1;
                                end
                            end
                        end
                        CMD_UNLOCK: begin
                            if (!mid_ok) r_res.status <= ST_NOT_FOUND;
                            else if (!r_locked[mid]) r_res.status <= ST_NOT_LOCKED;
                            else if (r_owner[mid] != r_req.proc_id)
                                r_res.status <= ST_DENIED;
                            else if (r_cnt[mid] == '0) begin
                                r_locked[mid] <= 1'b0;
                            end
                        end
                        CMD_DETECT: r_ev <= '0;
                        CMD_CLEAR: ;
                        default: r_res.status <= ST_NOT_FOUND;
                    endcase
                end
                S_CREATE: begin
                    if (r_res.status != ST_FULL) begin
                        if (!r_active[r_m]) begin
                            r_active[r_m] <= 1'b1;
                            r_locked[r_m] <= 1'b0;
                            r_cnt[r_m]    <= '0;
                            r_in_use      <= r_in_use + UW'(1);
                            r_res.new_slot <= 4'(r_m);
                        end else if (last_m) begin
                            r_res.status <= ST_FULL;
                        end
                    end
                    r_m <= r_m + MW'(1);
                end
                S_RD_HEAD: begin
                    r_res.new_owner  <= q_rdata;
                    r_res.handed_off <= 1'b1;
                    r_owner[mid]     <= q_rdata;
                end
                S_SHIFT: begin
                    if (32'(r_j) + 1 < 32'(r_cnt[mid])) r_j <= r_j + CW'(1);
                    else r_cnt[mid] <= r_cnt[mid] - CW'(1);
                end
                S_CLEAR: begin
                    r_active[r_m] <= 1'b0;
                    r_locked[r_m] <= 1'b0;
                    r_cnt[r_m]    <= '0;
                    r_in_use      <= '0;
                    r_m           <= r_m + MW'(1);
                end
                S_BUILD: begin
                    // read issued this cycle lands next cycle; apply the prior one
                    if (r_rd_ok && 32'(q_rdata) < PROC_SLOTS) begin
                        r_ev[PW'(q_rdata)]  <= 1'b1;
                        r_eto[PW'(q_rdata)] <= r_rd_own;
                    end
                    r_rd_own <= r_owner[r_m];
                    if (r_active[r_m] && r_locked[r_m] && r_j < r_cnt[r_m]) begin
                        r_rd_ok <= 1'b1;
                        r_j     <= r_j + CW'(1);
                    end else begin
                        r_rd_ok <= 1'b0;
                        r_j     <= '0;
                        r_m     <= r_m + MW'(1);
                    end
                end
                S_WALK_INIT: begin
                    if (r_rd_ok && 32'(q_rdata) < PROC_SLOTS) begin
                        r_ev[PW'(q_rdata)]  <= 1'b1;
                        r_eto[PW'(q_rdata)] <= r_rd_own;
                    end
                    r_rd_ok <= 1'b0;
                    r_s     <= '0;
                    r_node  <= '0;
                    r_k     <= '0;
                    r_ph    <= 1'b0;
                end
                S_WALK: begin
                    // a hop is taken in the evaluate phase after the map read; k counts hops from start r_s
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (walk_end) begin
                            r_s    <= r_s + PW'(1);
                            r_node <= 6'(r_s) + 6'd1;
                            r_k    <= '0;
                        end else if (32'(r_k) == PROC_SLOTS) begin
                            r_res.status <= ST_DEADLOCK;
                        end else begin
                            r_node <= r_eto_rd;
                            r_k    <= r_k + KW'(1);
                        end
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
